FILE: hdl/ppe_pkg.sv
`default_nettype none
package ppe_pkg;

  localparam int POOL_SIZE_DEFAULT = 64;

  localparam int SLOT_W  = 6;
  localparam int POS_W   = 24;
  localparam int LIFE_W  = 16;
  localparam int DT_W    = 12;
  localparam int SHADE_W = 9;
  localparam int ALPHA_W = 13;
  localparam int STEP_W  = 7;
  localparam int JIT_W   = 13;
  localparam int MUL_W   = 24;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int SUM_W   = POS_W + 3;

  localparam logic [LIFE_W-1:0]         LIFE_SPAN_RESET = 16'd3277;
  localparam logic [ALPHA_W-1:0]        ALPHA_ONE       = 13'd4096;
  // ceil(2^27 / 10): exact floor division by ten for operands below 2^26
  localparam logic [MUL_W-1:0]          RECIP_TEN       = 24'd13421773;
  localparam int                        RECIP_SHIFT     = 27;
  localparam int                        TICK_SHIFT      = 12;
  localparam logic [PROD_W-1:0]         TICK_HALF       = 48'd2048;
  localparam logic [MUL_W-1:0]          ROUND_FIVE      = 24'd5;
  localparam logic signed [POS_W-1:0]   POS_MAX         = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0]   POS_MIN         = 24'sh800000;

  typedef enum logic [1:0] {
    OP_SPAWN = 2'd0,
    OP_TICK  = 2'd1,
    OP_DUMP  = 2'd2
  } ppe_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SP_MX,
    ST_SP_MY,
    ST_SP_WR,
    ST_TK_RD,
    ST_TK_MX,
    ST_TK_MY,
    ST_TK_WR,
    ST_DP_RD,
    ST_DP_LD
  } ppe_state_e;

  typedef struct packed {
    logic [1:0]              op;
    logic [DT_W-1:0]         dt;
    logic signed [POS_W-1:0] obj_x;
    logic signed [POS_W-1:0] obj_y;
    logic signed [POS_W-1:0] obj_vx;
    logic signed [POS_W-1:0] obj_vy;
    logic signed [POS_W-1:0] offset_x;
    logic signed [POS_W-1:0] offset_y;
    logic [STEP_W-1:0]       jitter_step;
    logic [STEP_W-1:0]       shade_step;
  } ppe_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]       slot;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [SHADE_W-1:0]      shade;
    logic [ALPHA_W-1:0]      alpha;
    logic                    last;
  } ppe_out_t;

  // One pool slot as stored in the particle memory
  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] vel_x;
    logic signed [POS_W-1:0] vel_y;
    logic [SHADE_W-1:0]      shade;
    logic [ALPHA_W-1:0]      alpha;
    logic [LIFE_W-1:0]       life;
  } ppe_row_t;

  // Request to the shared multiply and saturating add unit
  typedef struct packed {
    logic                      mul_en;
    logic [MUL_W-1:0]          mul_a;
    logic [MUL_W-1:0]          mul_b;
    logic signed [POS_W-1:0]   add_a;
    logic signed [POS_W:0]     add_b;
    logic signed [JIT_W-1:0]   add_c;
  } ppe_alu_req_t;

  typedef logic signed [JIT_W-1:0] jit_tab_t [2**STEP_W];
  typedef logic [SHADE_W-1:0]      shade_tab_t [2**STEP_W];

  // round((step - 50) * 256 / 10), ties away from zero
  function automatic jit_tab_t build_jitter_table();
    jit_tab_t tab;
    int       n;
    for (int i = 0; i < 2**STEP_W; i++) begin
      n = (i - 50) * 256;
      if (n >= 0) begin
        tab[i] = JIT_W'((n + 5) / 10);
      end else begin
        tab[i] = JIT_W'(-((5 - n) / 10));
      end
    end
    return tab;
  endfunction

  // 128 + round(step * 256 / 100)
  function automatic shade_tab_t build_shade_table();
    shade_tab_t tab;
    for (int i = 0; i < 2**STEP_W; i++) begin
      tab[i] = SHADE_W'(128 + (i * 256 + 50) / 100);
    end
    return tab;
  endfunction

  localparam jit_tab_t   JITTER_TABLE = build_jitter_table();
  localparam shade_tab_t SHADE_TABLE  = build_shade_table();

  function automatic logic [MUL_W-1:0] mag24(logic signed [POS_W-1:0] v);
    logic signed [POS_W-1:0] neg;
    neg = -v;
    return v[POS_W-1] ? unsigned'(neg) : unsigned'(v);
  endfunction

endpackage
`default_nettype wire

FILE: hdl/ppe_mem.sv
`default_nettype none
module ppe_mem #(
  parameter int DEPTH = ppe_pkg::POOL_SIZE_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              rd_en_i,
  input  wire logic              wr_en_i,
  input  wire logic [AW-1:0]     addr_i,
  input  wire ppe_pkg::ppe_row_t wr_row_i,
  output ppe_pkg::ppe_row_t      rd_row_o
);
  import ppe_pkg::*;

  ppe_row_t mem_q [DEPTH];
  ppe_row_t rd_row_q;

  // Write one slot
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[addr_i] <= wr_row_i;
    end
  end

  // Registered read, held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_row_q <= mem_q[addr_i];
    end
  end

  assign rd_row_o = rd_row_q;

endmodule
`default_nettype wire

FILE: hdl/ppe_alu.sv
`default_nettype none
module ppe_alu (
  input  wire logic                  clk_i,
  input  wire ppe_pkg::ppe_alu_req_t req_i,
  output logic [ppe_pkg::PROD_W-1:0] prod_o,
  output logic signed [ppe_pkg::POS_W-1:0] sum_o
);
  import ppe_pkg::*;

  logic [PROD_W-1:0]      prod_q;
  logic signed [SUM_W-1:0] wide;

  // Register the product for use in the next step
  always_ff @(posedge clk_i) begin
    if (req_i.mul_en) begin
      prod_q <= PROD_W'(req_i.mul_a) * PROD_W'(req_i.mul_b);
    end
  end

  // Three-operand add, saturated to the position range
  always_comb begin
    wide = SUM_W'(req_i.add_a) + SUM_W'(req_i.add_b) + SUM_W'(req_i.add_c);
    if (wide > SUM_W'(POS_MAX)) begin
      sum_o = POS_MAX;
    end else if (wide < SUM_W'(POS_MIN)) begin
      sum_o = POS_MIN;
    end else begin
      sum_o = wide[POS_W-1:0];
    end
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

FILE: hdl/ppe_seq.sv
`default_nettype none
module ppe_seq #(
  parameter int POOL_SIZE = ppe_pkg::POOL_SIZE_DEFAULT,
  parameter int IDX_W     = $clog2(POOL_SIZE)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire ppe_pkg::ppe_in_t            in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output ppe_pkg::ppe_out_t                out_data_o,
  input  wire logic [ppe_pkg::LIFE_W-1:0]  life_span_i,
  output logic                             mem_rd_en_o,
  output logic                             mem_wr_en_o,
  output logic [IDX_W-1:0]                 mem_addr_o,
  output ppe_pkg::ppe_row_t                mem_wr_row_o,
  input  wire ppe_pkg::ppe_row_t           mem_rd_row_i,
  output ppe_pkg::ppe_alu_req_t            alu_req_o,
  input  wire logic [ppe_pkg::PROD_W-1:0]  alu_prod_i,
  input  wire logic signed [ppe_pkg::POS_W-1:0] alu_sum_i
);
  import ppe_pkg::*;

  ppe_state_e              state_q, state_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic [IDX_W-1:0]        cnt_q, cnt_d;
  logic [IDX_W-1:0]        ptr_q, ptr_d;
  logic [POOL_SIZE-1:0]    alive_q, alive_d;
  ppe_in_t                 item_q, item_d;
  logic signed [POS_W-1:0] nx_q, nx_d;
  logic signed [POS_W-1:0] vx_q, vx_d;
  logic [LIFE_W-1:0]       life_q, life_d;
  ppe_out_t                out_q, out_d;
  logic                    out_valid_q, out_valid_d;

  logic                    idx_last;
  logic [IDX_W-1:0]        idx_next;
  logic                    cur_alive;
  logic                    search_done;
  logic                    out_free;
  logic [POOL_SIZE-1:0]    higher;
  logic                    dump_last;
  logic [LIFE_W-1:0]       life_dec;
  logic [14:0]             fade_sum;
  logic [13:0]             fade;
  logic [ALPHA_W-1:0]      alpha_new;
  logic [PROD_W-1:0]       tick_sum;
  logic [POS_W-1:0]        tick_q;
  logic signed [POS_W:0]   tick_pos;
  logic                    tick_neg;
  logic signed [POS_W:0]   tick_step;
  logic signed [POS_W-1:0] spawn_mag;
  logic                    spawn_neg;
  logic signed [POS_W-1:0] spawn_vel;
  logic signed [JIT_W-1:0] jit;

  // Slot walk helpers
  assign idx_last    = (idx_q == IDX_W'(POOL_SIZE - 1));
  assign idx_next    = idx_last ? '0 : idx_q + 1'b1;
  assign cur_alive   = alive_q[idx_q];
  assign search_done = (cnt_q == IDX_W'(POOL_SIZE - 1));
  assign out_free    = !out_valid_q || out_ready_i;

  // Live slots beyond the current one decide the final dump item
  always_comb begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      higher[i] = alive_q[i] && (IDX_W'(i) > idx_q);
    end
  end
  assign dump_last = ~|higher;

  // Ageing and fading of the slot just read
  assign life_dec  = (mem_rd_row_i.life > LIFE_W'(item_q.dt)) ?
                     mem_rd_row_i.life - LIFE_W'(item_q.dt) : '0;
  assign fade_sum  = {1'b0, item_q.dt, 2'b00} + 15'(item_q.dt) + 15'd1;
  assign fade      = fade_sum[14:1];
  assign alpha_new = (14'(mem_rd_row_i.alpha) > fade) ?
                     mem_rd_row_i.alpha - fade[ALPHA_W-1:0] : '0;

  // Rounded velocity times dt, applied against the velocity sign
  assign tick_sum  = alu_prod_i + TICK_HALF;
  assign tick_q    = tick_sum[TICK_SHIFT +: POS_W];
  assign tick_pos  = signed'({1'b0, tick_q});
  assign tick_neg  = (state_q == ST_TK_WR) ? mem_rd_row_i.vel_y[POS_W-1] :
                                             mem_rd_row_i.vel_x[POS_W-1];
  assign tick_step = tick_neg ? tick_pos : -tick_pos;

  // Spawn velocity: rounded tenth of the object velocity
  assign spawn_mag = signed'(POS_W'(alu_prod_i[PROD_W-1:RECIP_SHIFT]));
  assign spawn_neg = (state_q == ST_SP_WR) ? item_q.obj_vy[POS_W-1] :
                                             item_q.obj_vx[POS_W-1];
  assign spawn_vel = spawn_neg ? -spawn_mag : spawn_mag;

  assign jit = JITTER_TABLE[item_q.jitter_step];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.op)
            OP_SPAWN: state_d = ST_SRCH;
            OP_TICK:  state_d = ST_TK_RD;
            OP_DUMP:  state_d = ST_DP_RD;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_SRCH: begin
        if (!cur_alive || search_done) begin
          state_d = ST_SP_MX;
        end
      end
      ST_SP_MX: state_d = ST_SP_MY;
      ST_SP_MY: state_d = ST_SP_WR;
      ST_SP_WR: state_d = ST_IDLE;
      ST_TK_RD: begin
        if (cur_alive) begin
          state_d = ST_TK_MX;
        end else if (idx_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_TK_MX: begin
        if (life_dec != '0) begin
          state_d = ST_TK_MY;
        end else begin
          state_d = idx_last ? ST_IDLE : ST_TK_RD;
        end
      end
      ST_TK_MY: state_d = ST_TK_WR;
      ST_TK_WR: state_d = idx_last ? ST_IDLE : ST_TK_RD;
      ST_DP_RD: begin
        if (cur_alive) begin
          state_d = ST_DP_LD;
        end else if (idx_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_DP_LD: begin
        if (out_free) begin
          state_d = (idx_last || dump_last) ? ST_IDLE : ST_DP_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and bookkeeping registers
  always_comb begin
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    alive_d     = alive_q;
    item_d      = item_q;
    nx_d        = nx_q;
    vx_d        = vx_q;
    life_d      = life_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          idx_d  = (in_data_i.op == OP_SPAWN) ? ptr_q : '0;
          cnt_d  = '0;
        end
      end
      ST_SRCH: begin
        if (!cur_alive) begin
          ptr_d = idx_q;
        end else if (search_done) begin
          // Full pool: fall back to slot zero
          idx_d = '0;
          ptr_d = '0;
        end else begin
          idx_d = idx_next;
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SP_MX: nx_d = alu_sum_i;
      ST_SP_MY: vx_d = spawn_vel;
      ST_SP_WR: alive_d[idx_q] = (life_span_i != '0);
      ST_TK_RD, ST_DP_RD: begin
        if (!cur_alive && !idx_last) begin
          idx_d = idx_next;
        end
      end
      ST_TK_MX: begin
        life_d = life_dec;
        if (life_dec == '0) begin
          alive_d[idx_q] = 1'b0;
          if (!idx_last) begin
            idx_d = idx_next;
          end
        end
      end
      ST_TK_MY: nx_d = alu_sum_i;
      ST_TK_WR: begin
        if (!idx_last) begin
          idx_d = idx_next;
        end
      end
      ST_DP_LD: begin
        if (out_free) begin
          out_d.slot  = SLOT_W'(idx_q);
          out_d.pos_x = mem_rd_row_i.pos_x;
          out_d.pos_y = mem_rd_row_i.pos_y;
          out_d.shade = mem_rd_row_i.shade;
          out_d.alpha = mem_rd_row_i.alpha;
          out_d.last  = dump_last;
          out_valid_d = 1'b1;
          if (!idx_last && !dump_last) begin
            idx_d = idx_next;
          end
        end
      end
      default: ;
    endcase
  end

  // Memory and shared unit requests
  always_comb begin
    in_ready_o        = 1'b0;
    mem_rd_en_o       = 1'b0;
    mem_wr_en_o       = 1'b0;
    mem_wr_row_o      = mem_rd_row_i;
    alu_req_o         = '0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_TK_RD, ST_DP_RD: mem_rd_en_o = cur_alive;
      ST_SP_MX: begin
        alu_req_o.mul_en = 1'b1;
        alu_req_o.mul_a  = mag24(item_q.obj_vx) + ROUND_FIVE;
        alu_req_o.mul_b  = RECIP_TEN;
        alu_req_o.add_a  = item_q.obj_x;
        alu_req_o.add_b  = (POS_W + 1)'(item_q.offset_x);
        alu_req_o.add_c  = jit;
      end
      ST_SP_MY: begin
        alu_req_o.mul_en = 1'b1;
        alu_req_o.mul_a  = mag24(item_q.obj_vy) + ROUND_FIVE;
        alu_req_o.mul_b  = RECIP_TEN;
      end
      ST_SP_WR: begin
        alu_req_o.add_a    = item_q.obj_y;
        alu_req_o.add_b    = (POS_W + 1)'(item_q.offset_y);
        alu_req_o.add_c    = jit;
        mem_wr_en_o        = 1'b1;
        mem_wr_row_o.pos_x = nx_q;
        mem_wr_row_o.pos_y = alu_sum_i;
        mem_wr_row_o.vel_x = vx_q;
        mem_wr_row_o.vel_y = spawn_vel;
        mem_wr_row_o.shade = SHADE_TABLE[item_q.shade_step];
        mem_wr_row_o.alpha = ALPHA_ONE;
        mem_wr_row_o.life  = life_span_i;
      end
      ST_TK_MX: begin
        alu_req_o.mul_en = 1'b1;
        alu_req_o.mul_a  = mag24(mem_rd_row_i.vel_x);
        alu_req_o.mul_b  = MUL_W'(item_q.dt);
      end
      ST_TK_MY: begin
        alu_req_o.mul_en = 1'b1;
        alu_req_o.mul_a  = mag24(mem_rd_row_i.vel_y);
        alu_req_o.mul_b  = MUL_W'(item_q.dt);
        alu_req_o.add_a  = mem_rd_row_i.pos_x;
        alu_req_o.add_b  = tick_step;
      end
      ST_TK_WR: begin
        alu_req_o.add_a    = mem_rd_row_i.pos_y;
        alu_req_o.add_b    = tick_step;
        mem_wr_en_o        = 1'b1;
        mem_wr_row_o.pos_x = nx_q;
        mem_wr_row_o.pos_y = alu_sum_i;
        mem_wr_row_o.alpha = alpha_new;
        mem_wr_row_o.life  = life_q;
      end
      default: ;
    endcase
  end

  assign mem_addr_o  = idx_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      ptr_q       <= '0;
      alive_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      alive_q     <= alive_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    nx_q   <= nx_d;
    vx_q   <= vx_d;
    life_q <= life_d;
    out_q  <= out_d;
  end

endmodule
`default_nettype wire

FILE: hdl/particle_pool_engine.sv
// Spawn: a free-slot search over up to POOL_SIZE slots, then the x step, y step and write.
// Tick: a free slot is skipped, an expiring slot is read and freed, and a surviving slot
// is read, aged, moved in x and y and written back. Dump: walks the slots up to the last
// live one (every slot if none is live), reading out each live slot; output stalls hold it.
// Reset (asynchronous, active low) frees every slot, zeroes the search pointer and sets
// life_span to 3277; particle memory contents need no clearing pass.
`default_nettype none
module particle_pool_engine #(
  parameter int POOL_SIZE = ppe_pkg::POOL_SIZE_DEFAULT
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire ppe_pkg::ppe_in_t           in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output ppe_pkg::ppe_out_t               out_data_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [ppe_pkg::LIFE_W-1:0] cfg_data_i
);
  import ppe_pkg::*;

  localparam int IdxW = $clog2(POOL_SIZE);

  logic [LIFE_W-1:0]       life_span_q;
  logic                    mem_rd_en;
  logic                    mem_wr_en;
  logic [IdxW-1:0]         mem_addr;
  ppe_row_t                mem_wr_row;
  ppe_row_t                mem_rd_row;
  ppe_alu_req_t            alu_req;
  logic [PROD_W-1:0]       alu_prod;
  logic signed [POS_W-1:0] alu_sum;

  // Hold the life given to new particles
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      life_span_q <= LIFE_SPAN_RESET;
    end else if (cfg_valid_i) begin
      life_span_q <= cfg_data_i;
    end
  end

  ppe_seq #(
    .POOL_SIZE (POOL_SIZE),
    .IDX_W     (IdxW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o),
    .life_span_i  (life_span_q),
    .mem_rd_en_o  (mem_rd_en),
    .mem_wr_en_o  (mem_wr_en),
    .mem_addr_o   (mem_addr),
    .mem_wr_row_o (mem_wr_row),
    .mem_rd_row_i (mem_rd_row),
    .alu_req_o    (alu_req),
    .alu_prod_i   (alu_prod),
    .alu_sum_i    (alu_sum)
  );

  ppe_mem #(
    .DEPTH (POOL_SIZE),
    .AW    (IdxW)
  ) u_mem (
    .clk_i    (clk_i),
    .rd_en_i  (mem_rd_en),
    .wr_en_i  (mem_wr_en),
    .addr_i   (mem_addr),
    .wr_row_i (mem_wr_row),
    .rd_row_o (mem_rd_row)
  );

  ppe_alu u_alu (
    .clk_i  (clk_i),
    .req_i  (alu_req),
    .prod_o (alu_prod),
    .sum_o  (alu_sum)
  );

endmodule
`default_nettype wire
